// ===== rtl/utf8_to_latin1_ascii_transcoder_defines.svh =====
// assertion macros for the utf-8 to latin-1 / ascii transcoder
`ifndef UTF8_TO_LATIN1_ASCII_TRANSCODER_DEFINES_SVH
`define UTF8_TO_LATIN1_ASCII_TRANSCODER_DEFINES_SVH

`ifndef SYNTHESIS

// pre holds at an edge, so post holds at the same edge
`define U2L_ASSERT_IMPLY(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("u2l assertion failed: implication");

// cond never holds
`define U2L_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("u2l assertion failed: forbidden condition");

`else

`define U2L_ASSERT_IMPLY(lbl, pre, post)
`define U2L_ASSERT_NEVER(lbl, cond)

`endif

`endif

// ===== rtl/u2l_pkg.sv =====
// shared types, codes and helpers of the utf-8 to latin-1 / ascii transcoder
package u2l_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } u2l_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       kind;
      logic       encode_error;
      logic       run_last;
   } u2l_rsp_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_LITERAL,
      ACT_REPLACE,
      ACT_ESCAPE
   } act_type;

   typedef enum logic [1:0] {
      ESC_HEX2,
      ESC_HEX4,
      ESC_HEX8
   } esc_type;

   // one classified request, handed from the front to the back
   typedef struct packed {
      act_type     act;
      esc_type     esc;
      logic [20:0] code_point;
      logic        end_flag;
      logic        err_flag;
   } u2l_job_type;

   localparam logic [1:0] MODE_STRICT  = 2'd0;
   localparam logic [1:0] MODE_IGNORE  = 2'd1;
   localparam logic [1:0] MODE_REPLACE = 2'd2;
   localparam logic [1:0] MODE_ESCAPE  = 2'd3;

   localparam logic CSR_TARGET = 1'b0;
   localparam logic CSR_MODE   = 1'b1;

   localparam logic CHARSET_LATIN1 = 1'b0;
   localparam logic CHARSET_ASCII  = 1'b1;

   localparam logic [7:0] CHAR_QUESTION  = 8'h3f;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_X_LOWER   = 8'h78;
   localparam logic [7:0] CHAR_U_LOWER   = 8'h75;
   localparam logic [7:0] CHAR_U_UPPER   = 8'h55;

   // lower-case hex digit
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] wide;
      wide = {4'b0000, nib};
      if (nib < 4'd10) begin
         hex_char = 8'h30 + wide;
      end else begin
         hex_char = 8'h57 + wide;
      end
   endfunction

endpackage

// ===== rtl/u2l_front.sv =====
// front: takes requests, gathers utf-8 sequences and classifies each code point
module u2l_front
   import u2l_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  u2l_req_type req_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [1:0]  csr_data,
   input  logic        q_full,
   output logic        push,
   output u2l_job_type push_job
);

   logic        charset_ff, charset_in;
   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  pend_ff, pend_in;
   logic [20:0] acc_ff, acc_in;
   logic [7:0]  lead_ff, lead_in;
   logic        disc_ff, disc_in;

   logic        accept;
   logic [7:0]  b;
   logic        last;
   logic [2:0]  lw;
   logic        pt_valid;
   logic [20:0] pt;
   logic [1:0]  pend_gather;
   logic [20:0] acc_gather;
   logic [7:0]  lead_gather;
   logic        fits;
   logic        strict_hit;
   act_type     act;
   esc_type     esc;

   assign accept    = req_valid && !q_full;
   assign req_stall = q_full;
   assign b         = req_data.in_byte;
   assign last      = req_data.last_byte;

   always_comb begin
      if (b < 8'h80) begin
         lw = 3'd1;
      end else if (b[7:5] == 3'b110) begin
         lw = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         lw = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         lw = 3'd4;
      end else begin
         lw = 3'd0;
      end
   end

   // sequence gathering, before any error handling
   always_comb begin
      pend_gather = pend_ff;
      acc_gather  = acc_ff;
      lead_gather = lead_ff;
      pt_valid    = 1'b0;
      pt          = '0;
      if (!disc_ff) begin
         if (pend_ff != 2'd0) begin
            acc_gather  = {acc_ff[14:0], b[5:0]};
            pend_gather = pend_ff - 2'd1;
            if (pend_gather == 2'd0) begin
               pt_valid = 1'b1;
               pt       = acc_gather;
            end else if (last) begin
               // cut-off sequence stands as its lead byte
               pt_valid = 1'b1;
               pt       = {13'b0, lead_ff};
            end
         end else if (lw >= 3'd2 && !last) begin
            case (lw)
               3'd2:    acc_gather = {16'b0, b[4:0]};
               3'd3:    acc_gather = {17'b0, b[3:0]};
               default: acc_gather = {18'b0, b[2:0]};
            endcase
            pend_gather = 2'(lw - 3'd1);
            lead_gather = b;
         end else begin
            pt_valid = 1'b1;
            pt       = {13'b0, b};
         end
      end
   end

   always_comb begin
      if (charset_ff == CHARSET_ASCII) begin
         fits = (pt[20:7] == '0);
      end else begin
         fits = (pt[20:8] == '0);
      end
      strict_hit = 1'b0;
      if (!pt_valid) begin
         act = ACT_NONE;
      end else if (fits) begin
         act = ACT_LITERAL;
      end else begin
         unique case (mode_ff)
            MODE_STRICT: begin
               act        = ACT_NONE;
               strict_hit = 1'b1;
            end
            MODE_IGNORE:  act = ACT_NONE;
            MODE_REPLACE: act = ACT_REPLACE;
            MODE_ESCAPE:  act = ACT_ESCAPE;
            default:      act = ACT_NONE;
         endcase
      end
      if (pt[20:8] == '0) begin
         esc = ESC_HEX2;
      end else if (pt[20:16] == '0) begin
         esc = ESC_HEX4;
      end else begin
         esc = ESC_HEX8;
      end
   end

   always_comb begin
      pend_in = pend_ff;
      acc_in  = acc_ff;
      lead_in = lead_ff;
      disc_in = disc_ff;
      if (accept) begin
         if (last) begin
            pend_in = '0;
            acc_in  = '0;
            lead_in = '0;
            disc_in = 1'b0;
         end else begin
            pend_in = pend_gather;
            acc_in  = acc_gather;
            lead_in = lead_gather;
            disc_in = disc_ff || strict_hit;
         end
      end
   end

   always_comb begin
      charset_in = charset_ff;
      mode_in    = mode_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TARGET: charset_in = csr_data[0];
            CSR_MODE:   mode_in    = csr_data;
            default:    mode_in    = mode_ff;
         endcase
      end
   end

   assign push                = accept && (act != ACT_NONE || last);
   assign push_job.act        = act;
   assign push_job.esc        = esc;
   assign push_job.code_point = pt;
   assign push_job.end_flag   = last;
   assign push_job.err_flag   = disc_ff || strict_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         charset_ff <= CHARSET_LATIN1;
         mode_ff    <= MODE_STRICT;
         pend_ff    <= '0;
         acc_ff     <= '0;
         lead_ff    <= '0;
         disc_ff    <= 1'b0;
      end else begin
         charset_ff <= charset_in;
         mode_ff    <= mode_in;
         pend_ff    <= pend_in;
         acc_ff     <= acc_in;
         lead_ff    <= lead_in;
         disc_ff    <= disc_in;
      end
   end

endmodule

// ===== rtl/u2l_queue.sv =====
// two-entry job queue between front and back
module u2l_queue
   import u2l_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  u2l_job_type push_job,
   input  logic        pop,
   output logic        full,
   output logic        head_valid,
   output u2l_job_type head_job
);

   u2l_job_type mem_ff [2];
   logic [1:0]  count_ff, count_in;
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = pop ? !rd_ff : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/u2l_back.sv =====
// back: expands each job into output bytes and the end marker
module u2l_back
   import u2l_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  u2l_job_type head_job,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output u2l_rsp_type rsp_data
);

   logic [3:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   u2l_rsp_type rsp_data_ff, rsp_data_in;

   logic [3:0]  n_data;
   logic [3:0]  n_dig;
   logic [3:0]  total;
   logic        last_step;
   logic        load;
   logic [2:0]  nib_idx;
   logic [31:0] cp_pad;
   logic [3:0]  nib;
   logic [7:0]  letter;
   logic [7:0]  data_byte;

   always_comb begin
      case (head_job.esc)
         ESC_HEX2: begin
            n_dig  = 4'd2;
            letter = CHAR_X_LOWER;
         end
         ESC_HEX4: begin
            n_dig  = 4'd4;
            letter = CHAR_U_LOWER;
         end
         default: begin
            n_dig  = 4'd8;
            letter = CHAR_U_UPPER;
         end
      endcase
      case (head_job.act)
         ACT_LITERAL: n_data = 4'd1;
         ACT_REPLACE: n_data = 4'd1;
         ACT_ESCAPE:  n_data = n_dig + 4'd2;
         default:     n_data = 4'd0;
      endcase
   end

   assign total     = n_data + {3'b000, head_job.end_flag};
   assign last_step = (step_ff == total - 4'd1);

   // digits go out most significant first, after the backslash and letter
   assign nib_idx = 3'(n_dig + 4'd1 - step_ff);
   assign cp_pad  = {11'b0, head_job.code_point};
   assign nib     = 4'(cp_pad >> {nib_idx, 2'b00});

   always_comb begin
      case (head_job.act)
         ACT_LITERAL: data_byte = head_job.code_point[7:0];
         ACT_REPLACE: data_byte = CHAR_QUESTION;
         ACT_ESCAPE: begin
            if (step_ff == 4'd0) begin
               data_byte = CHAR_BACKSLASH;
            end else if (step_ff == 4'd1) begin
               data_byte = letter;
            end else begin
               data_byte = hex_char(nib);
            end
         end
         default: data_byte = 8'h00;
      endcase
   end

   always_comb begin
      if (step_ff >= n_data) begin
         rsp_data_in.out_byte     = 8'h00;
         rsp_data_in.kind         = 1'b1;
         rsp_data_in.encode_error = head_job.err_flag;
      end else begin
         rsp_data_in.out_byte     = data_byte;
         rsp_data_in.kind         = 1'b0;
         rsp_data_in.encode_error = 1'b0;
      end
      rsp_data_in.run_last = last_step;
   end

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && last_step;

   always_comb begin
      step_in = step_ff;
      if (load) begin
         step_in = last_step ? 4'd0 : step_ff + 4'd1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/utf8_to_latin1_ascii_transcoder.sv =====
// top level of the utf-8 to latin-1 / ascii transcoder
// Takes one UTF-8 byte per request and emits Latin-1 or ASCII bytes, closing each
// string with an end marker that carries the strict-mode error flag. A request is
// taken every cycle while the two-entry job queue has room; the output sequencer
// emits one result per cycle unless stalled; a plain or replaced byte gives one
// byte, an escape 4 (\xNN), 6 (\uNNNN) or 10 (\UNNNNNNNN), an end marker one
// more. Requests stall only while the queue is full behind a longer expansion or
// a stalled output. Configuration writes take effect on the next request.
`include "utf8_to_latin1_ascii_transcoder_defines.svh"

module utf8_to_latin1_ascii_transcoder
   import u2l_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  u2l_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output u2l_rsp_type rsp_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [1:0]  csr_data
);

   logic        q_full;
   logic        push;
   u2l_job_type push_job;
   logic        pop;
   logic        head_valid;
   u2l_job_type head_job;

   u2l_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .push      (push),
      .push_job  (push_job)
   );

   u2l_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   u2l_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   `U2L_ASSERT_IMPLY(a_end_is_run_last, rsp_valid && rsp_data.kind, rsp_data.run_last)
   `U2L_ASSERT_IMPLY(a_data_no_error, rsp_valid && !rsp_data.kind, !rsp_data.encode_error)
   `U2L_ASSERT_NEVER(a_end_byte_zero, rsp_valid && rsp_data.kind && rsp_data.out_byte != 8'h00)
   `U2L_ASSERT_IMPLY(a_stall_needs_backlog, req_stall, head_valid && rsp_valid)

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the utf-8 to latin-1 / ascii transcoder
`timescale 1ns / 100ps

module tb_top;
   import u2l_pkg::*;

   localparam int    WATCHDOG_LIMIT   = 2000;
   localparam int    DRAIN_CYCLES     = 24;
   localparam int    RANDOM_PER_PHASE = 8;
   localparam string HEX_DIGITS       = "0123456789abcdef";

   // expected output stream, built by re-encoding every accepted request
   class encoded_stream;
      logic        charset;
      logic [1:0]  mode;
      logic [1:0]  pending_cont;
      logic [20:0] accum;
      logic [7:0]  lead;
      logic        discarding;
      u2l_rsp_type owed[$];
      int          mismatches;

      function new();
         charset      = CHARSET_LATIN1;
         mode         = MODE_STRICT;
         pending_cont = 2'd0;
         accum        = 21'd0;
         lead         = 8'd0;
         discarding   = 1'b0;
         mismatches   = 0;
      endfunction

      function void set_config(logic new_charset, logic [1:0] new_mode);
         charset = new_charset;
         mode    = new_mode;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function void emit(logic [7:0] b, logic is_end, logic err);
         u2l_rsp_type r;
         r.out_byte     = b;
         r.kind         = is_end;
         r.encode_error = err;
         r.run_last     = 1'b0;
         owed.insert(owed.size(), r);
      endfunction

      function void emit_hex(logic [31:0] value, int digits);
         int nib;
         for (int k = digits - 1; k >= 0; k--) begin
            nib = int'((value >> (4 * k)) & 32'hf);
            emit(HEX_DIGITS[nib], 1'b0, 1'b0);
         end
      endfunction

      function void encode(logic [20:0] cp);
         logic fits;
         fits = (charset == CHARSET_ASCII) ? (cp < 21'd128) : (cp < 21'd256);
         if (fits) begin
            emit(cp[7:0], 1'b0, 1'b0);
         end else begin
            case (mode)
               MODE_IGNORE: ;
               MODE_REPLACE: emit(CHAR_QUESTION, 1'b0, 1'b0);
               MODE_ESCAPE: begin
                  emit(CHAR_BACKSLASH, 1'b0, 1'b0);
                  if (cp <= 21'hff) begin
                     emit(CHAR_X_LOWER, 1'b0, 1'b0);
                     emit_hex({11'd0, cp}, 2);
                  end else if (cp <= 21'hffff) begin
                     emit(CHAR_U_LOWER, 1'b0, 1'b0);
                     emit_hex({11'd0, cp}, 4);
                  end else begin
                     emit(CHAR_U_UPPER, 1'b0, 1'b0);
                     emit_hex({11'd0, cp}, 8);
                  end
               end
               default: discarding = 1'b1;
            endcase
         end
      endfunction

      function int lead_len(logic [7:0] b);
         if (b < 8'h80) return 1;
         if (b >= 8'hc0 && b <= 8'hdf) return 2;
         if (b >= 8'he0 && b <= 8'hef) return 3;
         if (b >= 8'hf0 && b <= 8'hf7) return 4;
         return 0;
      endfunction

      // returns 1 when the request was not swallowed by a strict-mode error
      function bit take_request(u2l_req_type req);
         bit          taken;
         int          w;
         int          start;
         taken = !discarding;
         start = owed.size();
         if (!discarding) begin
            if (pending_cont != 2'd0) begin
               accum = {accum[14:0], req.in_byte[5:0]};
               pending_cont = pending_cont - 2'd1;
               if (pending_cont == 2'd0) begin
                  encode(accum);
               end else if (req.last_byte) begin
                  // cut-off sequence: the lead byte stands for itself
                  encode({13'd0, lead});
               end
            end else begin
               w = lead_len(req.in_byte);
               if (w >= 2 && !req.last_byte) begin
                  case (w)
                     2: accum = {16'd0, req.in_byte[4:0]};
                     3: accum = {17'd0, req.in_byte[3:0]};
                     default: accum = {18'd0, req.in_byte[2:0]};
                  endcase
                  pending_cont = 2'(w - 1);
                  lead = req.in_byte;
               end else begin
                  encode({13'd0, req.in_byte});
               end
            end
         end
         if (req.last_byte) begin
            emit(8'd0, 1'b1, discarding);
            pending_cont = 2'd0;
            accum        = 21'd0;
            lead         = 8'd0;
            discarding   = 1'b0;
         end
         if (owed.size() > start) begin
            owed[owed.size() - 1].run_last = 1'b1;
         end
         return taken;
      endfunction

      task flag_mismatch(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task match_result(u2l_rsp_type got);
         u2l_rsp_type want;
         if (owed.size() == 0) begin
            flag_mismatch($sformatf("result with nothing expected: byte %h kind %b err %b last %b",
                                    got.out_byte, got.kind, got.encode_error, got.run_last));
            return;
         end
         want = owed.pop_front();
         if (got.out_byte !== want.out_byte)
            flag_mismatch($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
         if (got.kind !== want.kind)
            flag_mismatch($sformatf("kind %b, expected %b", got.kind, want.kind));
         if (got.encode_error !== want.encode_error)
            flag_mismatch($sformatf("encode_error %b, expected %b",
                                    got.encode_error, want.encode_error));
         if (got.run_last !== want.run_last)
            flag_mismatch($sformatf("run_last %b, expected %b", got.run_last, want.run_last));
      endtask
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   u2l_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   u2l_rsp_type rsp_data;
   logic        csr_write = 1'b0;
   logic        csr_index = CSR_TARGET;
   logic [1:0]  csr_data  = 2'd0;

   encoded_stream stream = new();
   int            consumed_count = 0;
   int            idle_cycles    = 0;
   int            burst_left     = 0;
   int            stall_span     = 0;
   int            stall_level    = 0;

   utf8_to_latin1_ascii_transcoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // request/result monitor, receiver stall pattern and watchdog
   always @(posedge clock) begin
      logic req_fire;
      logic rsp_fire;
      req_fire = req_valid && !req_stall;
      rsp_fire = rsp_valid && !rsp_stall;
      if (!reset) begin
         // note the request before checking, in case a result comes out the same cycle
         if (req_fire) begin
            if (stream.take_request(req_data)) consumed_count <= consumed_count + 1;
         end
         if (rsp_fire) stream.match_result(rsp_data);
         if (req_fire || rsp_fire) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (stall_span == 0) begin
            stall_span  = $urandom_range(16, 80);
            stall_level = $urandom_range(0, 3);
         end
         stall_span--;
         rsp_stall <= ($urandom_range(0, 3) < stall_level);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      u2l_req_type req;
      int          gap;
      req.in_byte   = b;
      req.last_byte = last;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (req_stall);
   endtask

   // wait until every expected result is out and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (stream.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic charset, input logic [1:0] mode);
      csr_write <= 1'b1;
      csr_index <= CSR_TARGET;
      csr_data  <= {1'b0, charset};
      @(posedge clock);
      csr_index <= CSR_MODE;
      csr_data  <= mode;
      @(posedge clock);
      csr_write <= 1'b0;
      stream.set_config(charset, mode);
   endtask

   // mostly well-formed sequences, some stray bytes, some strings cut mid-sequence
   task automatic send_random_string();
      logic [7:0] text[$];
      int         seqs;
      int         pick;
      int         width;
      int         tail_len;
      int         cut;
      tail_len = 1;
      seqs = $urandom_range(1, 6);
      for (int s = 0; s < seqs; s++) begin
         pick  = $urandom_range(0, 99);
         width = 1;
         if (pick < 30) begin
            text.insert(text.size(), 8'($urandom_range(0, 127)));
         end else if (pick < 80) begin
            width = (pick < 50) ? 2 : (pick < 65) ? 3 : 4;
            case (width)
               2: text.insert(text.size(), 8'hc0 | 8'($urandom_range(0, 31)));
               3: text.insert(text.size(), 8'he0 | 8'($urandom_range(0, 15)));
               default: text.insert(text.size(), 8'hf0 | 8'($urandom_range(0, 7)));
            endcase
            for (int c = 1; c < width; c++) begin
               if ($urandom_range(0, 9) == 0) text.insert(text.size(), 8'($urandom));
               else text.insert(text.size(), 8'h80 | 8'($urandom_range(0, 63)));
            end
         end else if (pick < 90) begin
            text.insert(text.size(), 8'($urandom_range(128, 191)));
         end else begin
            text.insert(text.size(), 8'($urandom));
         end
         tail_len = width;
      end
      if (tail_len > 1 && $urandom_range(0, 3) == 0) begin
         cut = $urandom_range(1, tail_len - 1);
         repeat (cut) void'(text.pop_back());
      end
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   initial begin
      int phase_start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // latin-1 with escapes: literals, stray bytes, \u and \U escapes, cut-off sequence
      load_settings(CHARSET_LATIN1, MODE_ESCAPE);
      send_byte(8'h41, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'he2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hac, 1'b0);
      send_byte(8'hf7, 1'b0);
      send_byte(8'hbf, 1'b0);
      send_byte(8'hbf, 1'b0);
      send_byte(8'hbf, 1'b0);
      send_byte(8'hc3, 1'b0);
      send_byte(8'ha9, 1'b0);
      send_byte(8'he2, 1'b0);
      send_byte(8'h82, 1'b1);
      settle();

      // ascii with escapes: \xNN form
      load_settings(CHARSET_ASCII, MODE_ESCAPE);
      send_byte(8'hc3, 1'b0);
      send_byte(8'ha9, 1'b0);
      send_byte(8'h7f, 1'b1);
      settle();

      // replace, including a lead byte that ends the string
      load_settings(CHARSET_ASCII, MODE_REPLACE);
      send_byte(8'hff, 1'b0);
      send_byte(8'hf4, 1'b1);
      settle();

      load_settings(CHARSET_ASCII, MODE_IGNORE);
      send_byte(8'h80, 1'b1);
      settle();

      // strict: error drops the rest of the string and flags the end marker
      load_settings(CHARSET_LATIN1, MODE_STRICT);
      send_byte(8'he2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hac, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b1);
      settle();

      for (int i = 0; i < 8; i++) begin
         load_settings(i[2], i[1:0]);
         phase_start = consumed_count;
         while (consumed_count - phase_start < RANDOM_PER_PHASE) send_random_string();
         settle();
      end

      if (stream.pending() != 0)
         stream.flag_mismatch($sformatf("%0d results never arrived", stream.pending()));
      if (stream.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== utf8_to_latin1_ascii_transcoder.f =====
+incdir+rtl
rtl/u2l_pkg.sv
rtl/u2l_front.sv
rtl/u2l_queue.sv
rtl/u2l_back.sv
rtl/utf8_to_latin1_ascii_transcoder.sv
tb/sv/tb_top.sv
